/* rtl/core/oamu_pkg.sv */
`default_nettype none

package oamu_pkg;

	// Byte memory size, kept as a power of two so the address wraps by truncation
	localparam int MEM_AW    = 16;
	localparam int MEM_BYTES = 2 ** MEM_AW;

	localparam logic [2:0] SP_REG = 3'd6;
	localparam logic [2:0] PC_REG = 3'd7;

	typedef enum logic [1:0] {
		FUNC_RESOLVE = 2'd0,
		FUNC_WR_REG  = 2'd1,
		FUNC_WR_MEM  = 2'd2,
		FUNC_NOP     = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		MODE_REG     = 3'd0,
		MODE_DEF     = 3'd1,
		MODE_INC     = 3'd2,
		MODE_INC_DEF = 3'd3,
		MODE_DEC     = 3'd4,
		MODE_DEC_DEF = 3'd5,
		MODE_INDEX   = 3'd6,
		MODE_FAULT   = 3'd7
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_WR_HI,
		S_PTR_LO,
		S_PTR_HI,
		S_PTR_CAP,
		S_OP_LO,
		S_OP_HI,
		S_OP_CAP,
		S_FINISH
	} state_t;

	typedef enum logic [2:0] {
		REG_NOP,
		REG_WRITE_DATA,
		REG_STEP_INC,
		REG_STEP_DEC,
		REG_TWO_INC,
		REG_TWO_DEC,
		REG_PC_INC
	} reg_op_t;

	typedef enum logic [2:0] {
		ADDR_NOP,
		ADDR_REG,
		ADDR_REG_DEC_STEP,
		ADDR_REG_DEC_TWO,
		ADDR_PC,
		ADDR_WORD,
		ADDR_INDEX
	} addr_op_t;

	typedef enum logic [2:0] {
		MEM_NOP,
		MEM_RD_LO,
		MEM_RD_HI,
		MEM_WR_LO,
		MEM_WR_HI
	} mem_op_t;

	typedef enum logic [1:0] {
		VAL_NOP,
		VAL_BYTE,
		VAL_WORD
	} val_op_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_FAULT,
		RES_REG,
		RES_MEM
	} res_sel_t;

	typedef struct packed {
		logic     item_load;
		reg_op_t  reg_op;
		addr_op_t addr_op;
		mem_op_t  mem_op;
		logic     lo_load;
		val_op_t  val_op;
		logic     out_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		func_t func;
		mode_t mode;
		logic  byte_op;
	} stat_t;

endpackage

`default_nettype wire

/* rtl/core/oamu_datapath.sv */
`default_nettype none

module oamu_datapath
	import oamu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output stat_t            stat,
	input  wire logic [1:0]  func,
	input  wire logic [2:0]  mode,
	input  wire logic [2:0]  reg_index,
	input  wire logic        byte_op,
	input  wire logic [15:0] address,
	input  wire logic [15:0] data,
	output logic      [15:0] operand_address,
	output logic      [15:0] operand_value,
	output logic             is_register,
	output logic             fault
);

	logic [15:0] regs_q [8];
	logic [7:0]  mem [MEM_BYTES];

	func_t       func_q;
	mode_t       mode_q;
	logic [2:0]  ridx_q;
	logic        byte_q;
	logic [15:0] addr_in_q;
	logic [15:0] data_q;

	logic [15:0] addr_q;
	logic [15:0] val_q;
	logic [7:0]  lo_q;
	logic [7:0]  rdata_q;

	logic [15:0]       reg_cur;
	logic [15:0]       pc_cur;
	logic [15:0]       step;
	logic [15:0]       word;
	logic [MEM_AW-1:0] mem_addr;

	assign reg_cur = regs_q[ridx_q];
	assign pc_cur  = regs_q[PC_REG];
	assign step    = (byte_q && ridx_q != SP_REG && ridx_q != PC_REG) ? 16'd1 : 16'd2;
	assign word    = {rdata_q, lo_q};

	assign stat.func    = func_q;
	assign stat.mode    = mode_q;
	assign stat.byte_op = byte_q;

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			func_q    <= func_t'(func);
			mode_q    <= mode_t'(mode);
			ridx_q    <= reg_index;
			byte_q    <= byte_op;
			addr_in_q <= address;
			data_q    <= data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			case (cmd.reg_op)
				REG_WRITE_DATA: regs_q[ridx_q] <= data_q;
				REG_STEP_INC:   regs_q[ridx_q] <= reg_cur + step;
				REG_STEP_DEC:   regs_q[ridx_q] <= reg_cur - step;
				REG_TWO_INC:    regs_q[ridx_q] <= reg_cur + 16'd2;
				REG_TWO_DEC:    regs_q[ridx_q] <= reg_cur - 16'd2;
				REG_PC_INC:     regs_q[PC_REG] <= pc_cur + 16'd2;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.addr_op)
			ADDR_REG:          addr_q <= reg_cur;
			ADDR_REG_DEC_STEP: addr_q <= reg_cur - step;
			ADDR_REG_DEC_TWO:  addr_q <= reg_cur - 16'd2;
			ADDR_PC:           addr_q <= pc_cur;
			ADDR_WORD:         addr_q <= word;
			ADDR_INDEX:        addr_q <= reg_cur + word;
			default: ;
		endcase
	end

	// Single byte port: one read or one write per cycle
	always_comb begin
		unique case (cmd.mem_op)
			MEM_RD_HI: mem_addr = addr_q[MEM_AW-1:0] + MEM_AW'(1);
			MEM_WR_LO: mem_addr = addr_in_q[MEM_AW-1:0];
			MEM_WR_HI: mem_addr = addr_in_q[MEM_AW-1:0] + MEM_AW'(1);
			default:   mem_addr = addr_q[MEM_AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_op == MEM_WR_LO) begin
			mem[mem_addr] <= data_q[7:0];
		end else if (cmd.mem_op == MEM_WR_HI) begin
			mem[mem_addr] <= data_q[15:8];
		end else if (cmd.mem_op == MEM_RD_LO || cmd.mem_op == MEM_RD_HI) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lo_load) begin
			lo_q <= rdata_q;
		end
		case (cmd.val_op)
			VAL_BYTE: val_q <= {8'h00, rdata_q};
			VAL_WORD: val_q <= word;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.res_sel)
				RES_FAULT: begin
					operand_address <= '0;
					operand_value   <= '0;
					is_register     <= 1'b0;
					fault           <= 1'b1;
				end
				RES_REG: begin
					operand_address <= {13'd0, ridx_q};
					operand_value   <= byte_q ? {8'h00, reg_cur[7:0]} : reg_cur;
					is_register     <= 1'b1;
					fault           <= 1'b0;
				end
				RES_MEM: begin
					operand_address <= addr_q;
					operand_value   <= val_q;
					is_register     <= 1'b0;
					fault           <= 1'b0;
				end
				default: begin
					operand_address <= '0;
					operand_value   <= '0;
					is_register     <= 1'b0;
					fault           <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/oamu_ctrl.sv */
`default_nettype none

module oamu_ctrl
	import oamu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_valid_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		out_valid_d   = out_valid_q && !out_ready;
		cmd.item_load = 1'b0;
		cmd.reg_op    = REG_NOP;
		cmd.addr_op   = ADDR_NOP;
		cmd.mem_op    = MEM_NOP;
		cmd.lo_load   = 1'b0;
		cmd.val_op    = VAL_NOP;
		cmd.out_load  = 1'b0;
		cmd.res_sel   = RES_ZERO;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				unique case (stat.func)
					FUNC_WR_REG: cmd.reg_op = REG_WRITE_DATA;
					FUNC_WR_MEM: begin
						cmd.mem_op = MEM_WR_LO;
						state_d    = S_WR_HI;
					end
					FUNC_RESOLVE: begin
						unique case (stat.mode)
							MODE_DEF: begin
								cmd.addr_op = ADDR_REG;
								state_d     = S_OP_LO;
							end
							MODE_INC: begin
								cmd.addr_op = ADDR_REG;
								cmd.reg_op  = REG_STEP_INC;
								state_d     = S_OP_LO;
							end
							MODE_INC_DEF: begin
								cmd.addr_op = ADDR_REG;
								cmd.reg_op  = REG_TWO_INC;
								state_d     = S_PTR_LO;
							end
							MODE_DEC: begin
								cmd.addr_op = ADDR_REG_DEC_STEP;
								cmd.reg_op  = REG_STEP_DEC;
								state_d     = S_OP_LO;
							end
							MODE_DEC_DEF: begin
								cmd.addr_op = ADDR_REG_DEC_TWO;
								cmd.reg_op  = REG_TWO_DEC;
								state_d     = S_PTR_LO;
							end
							MODE_INDEX: begin
								cmd.addr_op = ADDR_PC;
								cmd.reg_op  = REG_PC_INC;
								state_d     = S_PTR_LO;
							end
							default: ;
						endcase
					end
					default: ;
				endcase
			end
			S_WR_HI: begin
				cmd.mem_op = MEM_WR_HI;
				state_d    = S_FINISH;
			end
			S_PTR_LO: begin
				cmd.mem_op = MEM_RD_LO;
				state_d    = S_PTR_HI;
			end
			S_PTR_HI: begin
				cmd.mem_op  = MEM_RD_HI;
				cmd.lo_load = 1'b1;
				state_d     = S_PTR_CAP;
			end
			S_PTR_CAP: begin
				// Index mode adds the base register, read after the counter step
				cmd.addr_op = (stat.mode == MODE_INDEX) ? ADDR_INDEX : ADDR_WORD;
				state_d     = S_OP_LO;
			end
			S_OP_LO: begin
				cmd.mem_op = MEM_RD_LO;
				state_d    = S_OP_HI;
			end
			S_OP_HI: begin
				if (stat.byte_op) begin
					cmd.val_op = VAL_BYTE;
					state_d    = S_FINISH;
				end else begin
					cmd.mem_op  = MEM_RD_HI;
					cmd.lo_load = 1'b1;
					state_d     = S_OP_CAP;
				end
			end
			S_OP_CAP: begin
				cmd.val_op = VAL_WORD;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (stat.func != FUNC_RESOLVE) begin
					cmd.res_sel = RES_ZERO;
				end else if (stat.mode == MODE_REG) begin
					cmd.res_sel = RES_REG;
				end else if (stat.mode == MODE_FAULT) begin
					cmd.res_sel = RES_FAULT;
				end else begin
					cmd.res_sel = RES_MEM;
				end
				// Hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/operand_addressing_mode_unit.sv */
// Operand addressing-mode resolver: eight 16-bit registers (register 7 is the
// program counter, reset to zero) and a byte memory with one byte port, which
// must be loaded by write-memory requests before it is read. One request at a
// time is in work; the next is taken as soon as the sequencer returns to idle,
// while the previous result may still wait in the output register. From decode,
// register write, mode 0, fault and the unused function go straight to finish;
// a memory word write adds a state for the high byte; modes 1, 2 and 4 read the
// operand low byte and, for a word, the high byte over the single-byte memory
// port (one read or write per cycle, read data registered); modes 3, 5 and 6
// first read the pointer or index word. Each request ends with a return to idle.
`default_nettype none

module operand_addressing_mode_unit
	import oamu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [2:0]  mode,
	input  wire logic [2:0]  reg_index,
	input  wire logic        byte_op,
	input  wire logic [15:0] address,
	input  wire logic [15:0] data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [15:0] operand_address,
	output logic      [15:0] operand_value,
	output logic             is_register,
	output logic             fault
);

	// Command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	oamu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Register file, byte memory, address and value registers, result register
	oamu_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.func            (func),
		.mode            (mode),
		.reg_index       (reg_index),
		.byte_op         (byte_op),
		.address         (address),
		.data            (data),
		.operand_address (operand_address),
		.operand_value   (operand_value),
		.is_register     (is_register),
		.fault           (fault)
	);

endmodule

`default_nettype wire
